// File: sv/adc_serial_reader_averager_top_defines.svh
// ----------------------------------------------------------------------------
// ADC serial reader averager - assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef ADC_SERIAL_READER_AVERAGER_TOP_DEFINES_SVH
`define ADC_SERIAL_READER_AVERAGER_TOP_DEFINES_SVH

// clocked property, inactive during reset
`define ASRA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASRA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/asra_pkg.sv
// ----------------------------------------------------------------------------
// ADC serial reader averager - package
// Widths, codes and the result word type shared by the block and its checker.
// ----------------------------------------------------------------------------
package asra_pkg;

	localparam int SAMPLE_BITS = 18;
	localparam int AVG_COUNT   = 1024;
	localparam int AVG_LOG2    = $clog2(AVG_COUNT);

	localparam int OPC_W  = 2;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 1;
	localparam int TICK_W = 8;
	localparam int BIT_W  = 5;
	localparam int READ_W = SAMPLE_BITS + 1;
	localparam int SUM_W  = READ_W + AVG_LOG2 + 1;
	localparam int CNT_W  = AVG_LOG2 + 1;

	localparam logic [TICK_W-1:0] CONVERT_TICKS_RST = TICK_W'(40);

	// opcodes
	localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPC_W-1:0] OP_SINGLE = 2'd1;
	localparam logic [OPC_W-1:0] OP_AVG    = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ZERO_OFFSET   = 1'd0;
	localparam logic [IDX_W-1:0] REG_CONVERT_TICKS = 1'd1;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_CONV = 3'b010,
		PH_READ = 3'b100
	} phase_t;

	typedef struct packed {
		logic                     convert_level;
		logic                     clock_level;
		logic                     busy_res;
		logic                     reading_valid;
		logic signed [READ_W-1:0] reading;
		logic                     average_valid;
		logic signed [READ_W-1:0] average;
	} res_t;

endpackage

// File: sv/adc_serial_reader_averager_top.sv
// ----------------------------------------------------------------------------
// ADC serial reader averager - top level
// Tick-driven serial converter readout with offset correction and averaging.
// ----------------------------------------------------------------------------
// Each accepted word is one tick of the pin sequencer and yields exactly one
// result word. A word is taken every clock cycle while the output side keeps
// up; the result passes the stage-1 register, then the rounding of the
// average into a two-entry output queue, before it is presented. A single
// reading spans max(convert_ticks, 1) + 36 ticks, an averaged run AVG_COUNT
// times that. in_ready depends only on internal occupancy, not on out_ready.
module adc_serial_reader_averager_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [asra_pkg::IDX_W-1:0]       cfg_index,
	input  logic [asra_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [asra_pkg::OPC_W-1:0]       opcode,
	input  logic                             data_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             convert_level,
	output logic                             clock_level,
	output logic                             busy_res,
	output logic                             reading_valid,
	output logic signed [asra_pkg::READ_W-1:0] reading,
	output logic                             average_valid,
	output logic signed [asra_pkg::READ_W-1:0] average
);
	import asra_pkg::*;

	// configuration
	logic [CFG_W-1:0]  zero_offset_q;
	logic [TICK_W-1:0] convert_ticks_q;

	// sequencer state
	phase_t              phase_q;
	logic [TICK_W-1:0]   tick_q;
	logic [BIT_W-1:0]    bit_q;
	logic [SAMPLE_BITS-1:0] shift_q;
	logic                averaging_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]    taken_q;

	// next state and raw results
	phase_t              phase_n;
	logic [TICK_W-1:0]   tick_n;
	logic [BIT_W-1:0]    bit_n;
	logic [SAMPLE_BITS-1:0] shift_n;
	logic                averaging_n;
	logic signed [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0]    taken_n;
	logic                cnv_c, clk_c, rv_c, av_c;
	logic signed [READ_W-1:0] rd_c;

	// stage 1
	logic                valid_s1;
	logic                cnv_s1, clk_s1, busy_s1, rv_s1, av_s1;
	logic signed [READ_W-1:0] rd_s1;
	logic signed [SUM_W-1:0]  sum_s1;

	// output queue
	res_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop, in_acc;
	res_t       res_c;

	assign push     = valid_s1 && !count_q[1];
	assign pop      = out_valid && out_ready;
	assign in_ready = !valid_s1 || push;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q   <= '0;
			convert_ticks_q <= CONVERT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_OFFSET:   zero_offset_q   <= cfg_data;
				REG_CONVERT_TICKS: convert_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [TICK_W-1:0] ct;
		logic signed [READ_W-1:0] corr;
		phase_n     = phase_q;
		tick_n      = tick_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		averaging_n = averaging_q;
		sum_n       = sum_q;
		taken_n     = taken_q;
		cnv_c       = 1'b0;
		clk_c       = 1'b0;
		rv_c        = 1'b0;
		av_c        = 1'b0;
		rd_c        = '0;
		ct          = (convert_ticks_q == '0) ? TICK_W'(1) : convert_ticks_q;
		corr        = $signed({shift_q[SAMPLE_BITS-1], shift_q})
		            - $signed({zero_offset_q[CFG_W-1], zero_offset_q});

		if (phase_q != PH_CONV && phase_q != PH_READ) begin
			phase_n = PH_IDLE;
			if (opcode == OP_SINGLE || opcode == OP_AVG) begin
				averaging_n = (opcode == OP_AVG);
				sum_n       = '0;
				taken_n     = '0;
				phase_n     = PH_CONV;
				tick_n      = '0;
			end
		end

		unique case (phase_n)
			PH_CONV: begin
				cnv_c  = 1'b1;
				tick_n = tick_n + TICK_W'(1);
				if (tick_n >= ct) begin
					phase_n = PH_READ;
					tick_n  = '0;
					bit_n   = '0;
					shift_n = '0;
				end
			end
			PH_READ: begin
				if (tick_n == '0) begin
					// clock high: sample MSB first
					clk_c   = 1'b1;
					shift_n = {shift_q[SAMPLE_BITS-2:0], data_in};
					tick_n  = TICK_W'(1);
				end else begin
					tick_n = '0;
					bit_n  = bit_q + BIT_W'(1);
					if (bit_n >= BIT_W'(SAMPLE_BITS)) begin
						rv_c  = 1'b1;
						rd_c  = corr;
						bit_n = '0;
						if (averaging_n) begin
							sum_n   = sum_n + SUM_W'(corr);
							taken_n = taken_n + CNT_W'(1);
							if (taken_n >= CNT_W'(AVG_COUNT)) begin
								av_c        = 1'b1;
								phase_n     = PH_IDLE;
								averaging_n = 1'b0;
							end else begin
								phase_n = PH_CONV;
							end
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			averaging_q <= 1'b0;
			sum_q       <= '0;
			taken_q     <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q     <= phase_n;
				tick_q      <= tick_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				averaging_q <= averaging_n;
				sum_q       <= sum_n;
				taken_q     <= taken_n;
				valid_s1    <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnv_s1  <= cnv_c;
			clk_s1  <= clk_c;
			busy_s1 <= (phase_n != PH_IDLE);
			rv_s1   <= rv_c;
			rd_s1   <= rd_c;
			av_s1   <= av_c;
			sum_s1  <= sum_n;
		end
	end

	// rounded mean: trunc toward zero of (2*sum + N) / (2*N)
	always_comb begin
		logic signed [SUM_W+1:0] num;
		logic [SUM_W+1:0] mag, quo, avg_full;
		num      = $signed({sum_s1[SUM_W-1], sum_s1, 1'b0}) + (SUM_W+2)'(AVG_COUNT);
		mag      = num[SUM_W+1] ? (SUM_W+2)'(-num) : (SUM_W+2)'(num);
		quo      = mag >> (AVG_LOG2 + 1);
		avg_full = num[SUM_W+1] ? (SUM_W+2)'(-quo) : quo;

		res_c.convert_level = cnv_s1;
		res_c.clock_level   = clk_s1;
		res_c.busy_res      = busy_s1;
		res_c.reading_valid = rv_s1;
		res_c.reading       = rd_s1;
		res_c.average_valid = av_s1;
		res_c.average       = av_s1 ? $signed(avg_full[READ_W-1:0]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= res_c;
	end

	assign out_valid     = (count_q != '0);
	assign convert_level = fifo_q[rd_ptr_q].convert_level;
	assign clock_level   = fifo_q[rd_ptr_q].clock_level;
	assign busy_res      = fifo_q[rd_ptr_q].busy_res;
	assign reading_valid = fifo_q[rd_ptr_q].reading_valid;
	assign reading       = fifo_q[rd_ptr_q].reading;
	assign average_valid = fifo_q[rd_ptr_q].average_valid;
	assign average       = fifo_q[rd_ptr_q].average;

endmodule

// File: sv/asra_checker.sv
// ----------------------------------------------------------------------------
// ADC serial reader averager - port checker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "adc_serial_reader_averager_top_defines.svh"

module asra_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [asra_pkg::IDX_W-1:0]         cfg_index,
	input logic [asra_pkg::CFG_W-1:0]         cfg_data,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [asra_pkg::OPC_W-1:0]         opcode,
	input logic                               data_in,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               convert_level,
	input logic                               clock_level,
	input logic                               busy_res,
	input logic                               reading_valid,
	input logic signed [asra_pkg::READ_W-1:0] reading,
	input logic                               average_valid,
	input logic signed [asra_pkg::READ_W-1:0] average
);
	import asra_pkg::*;

	// stalled result word must hold
	`ASRA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(average) && $stable(busy_res), "result word changed while stalled")

	// an average always closes a reading
	`ASRA_ASSERT(a_avg_with_reading, out_valid && average_valid |-> reading_valid, "average without reading")

	// the run ends on the tick the average is reported
	`ASRA_ASSERT(a_avg_ends_run, out_valid && average_valid |-> !busy_res, "busy after average")

	// convert and serial clock phases never overlap
	`ASRA_NEVER(a_pins_exclusive, out_valid && convert_level && clock_level, "convert and clock both high")

endmodule

bind adc_serial_reader_averager_top asra_checker u_asra_checker (.*);
